@@ rtl/seg_pkg.sv @@
// ----------------------------------------------------------------------------
// Switch event generator package
// Shared payload types, codes and reset values for the switch event blocks.
// ----------------------------------------------------------------------------
package seg_pkg;

  localparam int SW_LEVEL_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ID   = 1'b1;

  localparam logic [15:0] LONG_PRESS_RST = 16'd500;
  localparam logic [5:0]  START_ID_RST   = 6'd0;

  localparam logic [7:0] CMD_MASK    = 8'hC0;
  localparam logic [7:0] CMD_ASK     = 8'h00;
  localparam logic [7:0] CMD_REPLY   = 8'h40;
  localparam logic [7:0] CMD_PRESS   = 8'h80;
  localparam logic [7:0] CMD_RELEASE = 8'hC0;
  localparam logic [7:0] ID_MASK     = 8'h3F;
  localparam logic [7:0] BYTE_NONE   = 8'h00;

  localparam logic [1:0] EV_PRESS   = 2'd0;
  localparam logic [1:0] EV_RELEASE = 2'd1;
  localparam logic [1:0] EV_LONG    = 2'd2;

  localparam logic KIND_SWITCH = 1'b0;
  localparam logic KIND_BYTE   = 1'b1;

  typedef struct packed {
    logic [23:0] switch_levels;
    logic [31:0] now_ms;
    logic        exp_valid;
    logic [7:0]  exp_byte;
  } seg_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [6:0]  switch_id;
    logic [1:0]  event_type;
    logic [7:0]  reply_byte;
    logic        last;
  } seg_out_t;

  typedef enum logic [1:0] {
    EXP_NONE,
    EXP_REPLY,
    EXP_PRESS,
    EXP_RELEASE
  } seg_exp_act_t;

  typedef struct packed {
    logic [23:0]  switch_levels;
    logic [31:0]  now_ms;
    seg_exp_act_t exp_act;
    logic [6:0]   exp_id;
  } seg_job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } seg_state_t;

endpackage

@@ rtl/seg_front.sv @@
// ----------------------------------------------------------------------------
// Switch event generator front end
// Accepts scan frames and decodes the expansion byte into an action and id.
// ----------------------------------------------------------------------------
module seg_front #(
  parameter int EXP_ID_BASE = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  seg_pkg::seg_in_t  in_data,
  output logic              push_valid,
  input  logic              push_ready,
  output seg_pkg::seg_job_t push_job
);
  import seg_pkg::*;

  seg_exp_act_t act;
  logic         busy_r;
  logic         busy_nxt;

  always_comb begin
    act = EXP_NONE;
    if (in_data.exp_valid) begin
      case (in_data.exp_byte & CMD_MASK)
        CMD_ASK:     act = EXP_REPLY;
        CMD_PRESS:   act = EXP_PRESS;
        CMD_RELEASE: act = EXP_RELEASE;
        default:     act = EXP_NONE;
      endcase
    end
  end

  // Set once a frame has been accepted since reset; not used elsewhere.
  always_comb begin
    busy_nxt = busy_r | (in_valid & push_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_job.switch_levels = in_data.switch_levels;
    push_job.now_ms        = in_data.now_ms;
    push_job.exp_act       = act;
    push_job.exp_id        = 7'(in_data.exp_byte & ID_MASK) + 7'(EXP_ID_BASE);
  end

endmodule

@@ rtl/seg_queue.sv @@
// ----------------------------------------------------------------------------
// Switch event generator job queue
// Short first-in first-out queue between the front end and the walker.
// ----------------------------------------------------------------------------
module seg_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  seg_pkg::seg_job_t push_job,
  output logic              pop_valid,
  input  logic              pop_ready,
  output seg_pkg::seg_job_t pop_job
);
  import seg_pkg::*;

  seg_job_t            entry_r [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0] wr_ptr_r;
  logic [QUEUE_PW-1:0] wr_ptr_nxt;
  logic [QUEUE_PW-1:0] rd_ptr_r;
  logic [QUEUE_PW-1:0] rd_ptr_nxt;
  logic [QUEUE_CW-1:0] count_r;
  logic [QUEUE_CW-1:0] count_nxt;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count_r != QUEUE_CW'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = entry_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ rtl/seg_back.sv @@
// ----------------------------------------------------------------------------
// Switch event generator walker
// Emits words, walking switches one per cycle unless stalled, then exp. action.
// ----------------------------------------------------------------------------
module seg_back #(
  parameter int NUM_SWITCHES = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  seg_pkg::seg_job_t job,
  input  logic [15:0]       long_press_ms,
  input  logic [5:0]        start_id,
  output logic              out_valid,
  input  logic              out_ready,
  output seg_pkg::seg_out_t out_data
);
  import seg_pkg::*;

  localparam int AW = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;
  localparam int CW = $clog2(NUM_SWITCHES + 1);
  localparam logic [CW-1:0] EXP_SLOT = CW'(NUM_SWITCHES);

  seg_state_t              state_r;
  seg_state_t              state_nxt;
  seg_job_t                job_r;
  seg_job_t                job_nxt;
  logic [CW-1:0]           slot_r;
  logic [CW-1:0]           slot_nxt;
  logic [NUM_SWITCHES-1:0] prev_r;
  logic [NUM_SWITCHES-1:0] prev_nxt;
  logic [NUM_SWITCHES-1:0] armed_r;
  logic [NUM_SWITCHES-1:0] armed_nxt;
  logic                    pend_valid_r;
  logic                    pend_valid_nxt;
  seg_out_t                pend_r;
  seg_out_t                pend_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  seg_out_t                out_r;
  seg_out_t                out_nxt;

  logic [31:0]             pt_mem [NUM_SWITCHES];
  logic [31:0]             pt_rdata_r;
  logic                    pt_we;
  logic [AW-1:0]           pt_raddr;

  logic [NUM_SWITCHES-1:0] lvl_ext;
  logic [AW-1:0]           slot_a;
  logic [CW-1:0]           slot_inc;
  logic                    is_sw;
  logic                    cur;
  logic                    prev;
  logic                    armed;
  logic [31:0]             held;
  logic                    long_hit;
  logic                    is_press;
  logic                    is_long;
  logic                    ev_hit;
  seg_out_t                ev;
  logic                    out_free;
  logic                    advance;

  for (genvar g = 0; g < NUM_SWITCHES; g++) begin : g_lvl
    if (g < SW_LEVEL_W) begin : g_in
      assign lvl_ext[g] = job_r.switch_levels[g];
    end else begin : g_off
      assign lvl_ext[g] = 1'b0;
    end
  end

  assign slot_a   = slot_r[AW-1:0];
  assign slot_inc = slot_r + 1'b1;
  assign is_sw    = (slot_r != EXP_SLOT);
  assign cur      = lvl_ext[slot_a];
  assign prev     = prev_r[slot_a];
  assign armed    = armed_r[slot_a];
  assign held     = job_r.now_ms - pt_rdata_r;
  assign long_hit = (held > {16'b0, long_press_ms});
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    ev       = '0;
    ev_hit   = 1'b0;
    is_press = 1'b0;
    is_long  = 1'b0;
    if (is_sw) begin
      ev.result_kind = KIND_SWITCH;
      ev.switch_id   = 7'(slot_r);
      if (cur && !prev) begin
        is_press      = 1'b1;
        ev_hit        = 1'b1;
        ev.event_type = EV_PRESS;
      end else if (!cur && prev) begin
        ev_hit        = 1'b1;
        ev.event_type = EV_RELEASE;
      end else if (cur && armed && long_hit) begin
        is_long       = 1'b1;
        ev_hit        = 1'b1;
        ev.event_type = EV_LONG;
      end
    end else begin
      case (job_r.exp_act)
        EXP_REPLY: begin
          ev_hit         = 1'b1;
          ev.result_kind = KIND_BYTE;
          ev.reply_byte  = {2'b00, start_id} | CMD_REPLY;
        end
        EXP_PRESS: begin
          ev_hit         = 1'b1;
          ev.result_kind = KIND_SWITCH;
          ev.switch_id   = job_r.exp_id;
          ev.event_type  = EV_PRESS;
          ev.reply_byte  = BYTE_NONE;
        end
        EXP_RELEASE: begin
          ev_hit         = 1'b1;
          ev.result_kind = KIND_SWITCH;
          ev.switch_id   = job_r.exp_id;
          ev.event_type  = EV_RELEASE;
          ev.reply_byte  = BYTE_NONE;
        end
        default: begin
          ev_hit = 1'b0;
        end
      endcase
    end
  end

  assign advance = !(ev_hit && pend_valid_r && !out_free);

  always_comb begin
    state_nxt      = state_r;
    job_nxt        = job_r;
    slot_nxt       = slot_r;
    prev_nxt       = prev_r;
    armed_nxt      = armed_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    job_ready      = 1'b0;
    pt_we          = 1'b0;
    pt_raddr       = slot_a;
    case (state_r)
      ST_IDLE: begin
        pt_raddr = '0;
        if (job_valid) begin
          job_ready = 1'b1;
          job_nxt   = job;
          slot_nxt  = '0;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (advance) begin
          if (is_sw) begin
            prev_nxt[slot_a] = cur;
            if (is_press) begin
              armed_nxt[slot_a] = 1'b1;
              pt_we             = 1'b1;
            end else if (is_long) begin
              armed_nxt[slot_a] = 1'b0;
            end
          end
          if (ev_hit) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = pend_r;
            end
            pend_valid_nxt = 1'b1;
            pend_nxt       = ev;
          end
          if (slot_r == EXP_SLOT) begin
            pt_raddr  = '0;
            state_nxt = ST_FLUSH;
          end else begin
            slot_nxt = slot_inc;
            pt_raddr = (slot_inc == EXP_SLOT) ? '0 : slot_inc[AW-1:0];
          end
        end
      end
      ST_FLUSH: begin
        pt_raddr = '0;
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_nxt        = pend_r;
          out_nxt.last   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_r       <= '0;
      prev_r       <= '0;
      armed_r      <= '1;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_r       <= slot_nxt;
      prev_r       <= prev_nxt;
      armed_r      <= armed_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[slot_a] <= job_r.now_ms;
    end
    pt_rdata_r <= pt_mem[pt_raddr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/switch_event_generator_core.sv @@
// ----------------------------------------------------------------------------
// Switch event generator
// Press, release and long-press detection over a scan frame of switch levels.
// ----------------------------------------------------------------------------
// Each word on the in_ channel is one scan frame: switch levels, the frame's
// millisecond time and an optional expansion byte. The block walks the
// switches in index order and then the expansion byte, and sends the events
// on the out_ channel, one word each, with last set on the frame's final one.
// A frame that causes no event gives no word.
// Registers are written on the cfg_ channel: index 0 is the long-press time
// in milliseconds, index 1 the start id placed in the reply byte.
// When the receiver does not stall, a frame is loaded, then each switch and
// then the expansion byte is walked through the press-time memory one entry
// a cycle, and then the last word is sent.
// An event word leaves once the next event of the frame is found, and the
// frame's last word leaves after the expansion byte has been walked.
// A two-frame queue lets new frames be accepted while the walker works.
// When the receiver stalls, the walker holds at the next event and the queue
// fills, after which in_ready drops.
// Reset clears all switches to released, arms every long press, sets the
// long-press time to 500 and the start id to 0. The walk needs no clearing.
// ----------------------------------------------------------------------------
module switch_event_generator_core #(
  parameter int NUM_SWITCHES = 24,
  parameter int EXP_ID_BASE  = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  seg_pkg::seg_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output seg_pkg::seg_out_t                out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [seg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [seg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import seg_pkg::*;

  logic [15:0] long_ms_r;
  logic [15:0] long_ms_nxt;
  logic [5:0]  start_id_r;
  logic [5:0]  start_id_nxt;
  logic        push_valid;
  logic        push_ready;
  seg_job_t    push_job;
  logic        pop_valid;
  logic        pop_ready;
  seg_job_t    pop_job;

  assign cfg_ready = 1'b1;

  always_comb begin
    long_ms_nxt  = long_ms_r;
    start_id_nxt = start_id_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_LONG_PRESS: long_ms_nxt  = cfg_data[15:0];
        CFG_START_ID:   start_id_nxt = cfg_data[5:0];
        default:        long_ms_nxt  = long_ms_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ms_r  <= LONG_PRESS_RST;
      start_id_r <= START_ID_RST;
    end else begin
      long_ms_r  <= long_ms_nxt;
      start_id_r <= start_id_nxt;
    end
  end

  seg_front #(
    .EXP_ID_BASE (EXP_ID_BASE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  seg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  seg_back #(
    .NUM_SWITCHES (NUM_SWITCHES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (pop_valid),
    .job_ready     (pop_ready),
    .job           (pop_job),
    .long_press_ms (long_ms_r),
    .start_id      (start_id_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

endmodule

@@ rtl/seg_sva.sv @@
// ----------------------------------------------------------------------------
// Switch event generator port checker
// Checks the result channel of the switch event generator over time.
// ----------------------------------------------------------------------------
module seg_sva (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input seg_pkg::seg_out_t out_data
);
  import seg_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result word changed while stalled.");

  a_reply_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == KIND_BYTE |->
      out_data.reply_byte[7:6] == 2'b01 && out_data.switch_id == 7'd0 &&
      out_data.event_type == EV_PRESS)
    else $error("Reply word is malformed.");

  a_event_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == KIND_SWITCH |->
      out_data.reply_byte == BYTE_NONE &&
      (out_data.event_type == EV_PRESS || out_data.event_type == EV_RELEASE ||
       out_data.event_type == EV_LONG))
    else $error("Switch event word is malformed.");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

endmodule

bind switch_event_generator_core seg_sva u_seg_sva (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Switch event generator testbench
// Drives scan frames and register writes into the core. A scoreboard tracks
// every switch's level, press time and long-press arming, and from that it
// predicts the press, release, long-press and expansion words of each frame.
// Every word the core sends is compared field by field against that
// prediction, under random idling on both channels and one long receiver
// stall that backs the core up.
// ----------------------------------------------------------------------------
module testbench;
  import seg_pkg::*;

  localparam int NUM_SW        = 24;
  localparam int EXP_BASE      = 24;
  localparam int SETTLE_CYCLES = 120;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 400000;

  class switch_event_scoreboard;
    logic [NUM_SW-1:0] level_q;
    logic [NUM_SW-1:0] armed;
    logic [31:0]       pressed_at [NUM_SW];
    logic [15:0]       hold_limit_ms;
    logic [5:0]        start_id;
    seg_out_t          expected_q [$];
    int                mismatches;
    int                frames_noted;
    int                press_words;
    int                release_words;
    int                long_words;
    int                reply_words;

    function new();
      level_q       = '0;
      armed         = '1;
      hold_limit_ms = LONG_PRESS_RST;
      start_id      = START_ID_RST;
      for (int i = 0; i < NUM_SW; i++) begin
        pressed_at[i] = '0;
      end
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_LONG_PRESS) begin
        hold_limit_ms = val;
      end else if (idx == CFG_START_ID) begin
        start_id = val[5:0];
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_frame(seg_in_t f);
      seg_out_t    w;
      seg_out_t    words [$];
      logic        cur;
      logic [31:0] held;
      logic [7:0]  cmd;
      frames_noted++;
      for (int i = 0; i < NUM_SW; i++) begin
        cur = (i < SW_LEVEL_W) ? f.switch_levels[i] : 1'b0;
        held = f.now_ms - pressed_at[i];
        w = '0;
        w.result_kind = KIND_SWITCH;
        w.switch_id = 7'(i);
        if (cur && !level_q[i]) begin
          pressed_at[i] = f.now_ms;
          armed[i] = 1'b1;
          w.event_type = EV_PRESS;
          words.push_back(w);
        end else if (!cur && level_q[i]) begin
          w.event_type = EV_RELEASE;
          words.push_back(w);
        end else if (cur && armed[i] && held > {16'd0, hold_limit_ms}) begin
          armed[i] = 1'b0;
          w.event_type = EV_LONG;
          words.push_back(w);
        end
        level_q[i] = cur;
      end
      if (f.exp_valid) begin
        cmd = f.exp_byte & CMD_MASK;
        w = '0;
        w.switch_id = 7'(EXP_BASE) + {1'b0, f.exp_byte[5:0]};
        if (cmd == CMD_ASK) begin
          w.result_kind = KIND_BYTE;
          w.switch_id = '0;
          w.reply_byte = {2'b00, start_id} | CMD_REPLY;
          words.push_back(w);
        end else if (cmd == CMD_PRESS) begin
          w.event_type = EV_PRESS;
          words.push_back(w);
        end else if (cmd == CMD_RELEASE) begin
          w.event_type = EV_RELEASE;
          words.push_back(w);
        end
      end
      if (words.size() > 0) begin
        words[words.size() - 1].last = 1'b1;
      end
      foreach (words[k]) begin
        expected_q.push_back(words[k]);
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(seg_out_t got);
      seg_out_t want;
      if (expected_q.size() == 0) begin
        $error("Word with no prediction waiting: %p", got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("result_kind", 8'(want.result_kind), 8'(got.result_kind));
      compare_field("switch_id", 8'(want.switch_id), 8'(got.switch_id));
      compare_field("event_type", 8'(want.event_type), 8'(got.event_type));
      compare_field("reply_byte", want.reply_byte, got.reply_byte);
      compare_field("last", 8'(want.last), 8'(got.last));
      if (want.result_kind == KIND_BYTE) begin
        reply_words++;
      end else if (want.event_type == EV_PRESS) begin
        press_words++;
      end else if (want.event_type == EV_RELEASE) begin
        release_words++;
      end else begin
        long_words++;
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  seg_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  seg_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  switch_event_scoreboard board;
  int          tx_idle_pct   = 0;
  int          rx_idle_pct   = 0;
  int          hold_requests = 0;
  int          holds_served  = 0;
  int          hold_left     = 0;
  int          cycle_count   = 0;
  logic [23:0] scan_levels   = '0;
  logic [31:0] clock_ms      = '0;

  switch_event_generator_core #(
    .NUM_SWITCHES(NUM_SW),
    .EXP_ID_BASE (EXP_BASE)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_word(out_data);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d words outstanding",
               board.pending());
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic seg_in_t scan_frame(logic [23:0] levels, logic [31:0] now,
                                         logic valid, logic [7:0] exp_byte);
    seg_in_t f;
    f.switch_levels = levels;
    f.now_ms = now;
    f.exp_valid = valid;
    f.exp_byte = exp_byte;
    return f;
  endfunction

  function automatic seg_in_t next_random_frame(int unsigned reach_ms);
    logic [23:0] flips;
    flips = 24'($urandom) & 24'($urandom) & 24'($urandom);
    if ($urandom_range(99) < 10) begin
      scan_levels = 24'($urandom);
    end else begin
      scan_levels = scan_levels ^ flips;
    end
    if ($urandom_range(99) < 5) begin
      clock_ms = $urandom;
    end else begin
      clock_ms = clock_ms + $urandom_range(reach_ms, 0);
    end
    return scan_frame(scan_levels, clock_ms, 1'($urandom_range(1)), 8'($urandom));
  endfunction

  task automatic send_frame(input seg_in_t f);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= f;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    board.note_frame(f);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    board.set_register(idx, val);
    @(posedge clk);
  endtask

  task automatic run_random(input logic [15:0] hold_ms, input logic [5:0] sid,
                            input int tx_pct, input int rx_pct, input int count,
                            input bit with_hold);
    settle();
    write_reg(CFG_LONG_PRESS, hold_ms);
    write_reg(CFG_START_ID, 16'(sid));
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    if (with_hold) begin
      hold_requests <= hold_requests + 1;
    end
    repeat (count) begin
      send_frame(next_random_frame(2 * int'(hold_ms) + 2));
    end
  endtask

  initial begin
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_pct = 29;
    rx_idle_pct <= 55;

    send_frame(scan_frame(24'h000000, 32'd1000, 1'b1, CMD_ASK));
    send_frame(scan_frame(24'h000020, 32'd1000, 1'b0, BYTE_NONE));
    send_frame(scan_frame(24'h000020, 32'd1500, 1'b0, BYTE_NONE));
    send_frame(scan_frame(24'h000020, 32'd1501, 1'b0, BYTE_NONE));
    send_frame(scan_frame(24'h000000, 32'd1502, 1'b0, BYTE_NONE));

    settle();
    write_reg(CFG_LONG_PRESS, 16'd0);
    write_reg(CFG_START_ID, 16'd63);
    send_frame(scan_frame(24'h000000, 32'd100, 1'b0, 8'hFF));
    send_frame(scan_frame(24'hFFFFFF, 32'd100, 1'b1, CMD_ASK));
    send_frame(scan_frame(24'hFFFFFF, 32'd100, 1'b0, BYTE_NONE));
    send_frame(scan_frame(24'hFFFFFF, 32'd101, 1'b0, BYTE_NONE));
    send_frame(scan_frame(24'hFFFFFF, 32'd5000, 1'b0, BYTE_NONE));
    send_frame(scan_frame(24'h000000, 32'd5001, 1'b1, CMD_PRESS | ID_MASK));
    send_frame(scan_frame(24'h000000, 32'd5002, 1'b1, CMD_RELEASE));
    send_frame(scan_frame(24'h000000, 32'd5003, 1'b1, CMD_REPLY | 8'h05));
    send_frame(scan_frame(24'h000001, 32'd5004, 1'b1, CMD_ASK | ID_MASK));
    send_frame(scan_frame(24'h800000, 32'd5005, 1'b1, 8'hFF));
    send_frame(scan_frame(24'h800001, 32'hFFFFFFFF, 1'b0, BYTE_NONE));
    send_frame(scan_frame(24'h800001, 32'h00000000, 1'b0, BYTE_NONE));
    send_frame(scan_frame(24'hAAAAAA, 32'd7, 1'b1, CMD_PRESS));
    send_frame(scan_frame(24'h555555, 32'd8, 1'b1, CMD_RELEASE | 8'h2A));
    send_frame(scan_frame(24'h000000, 32'd9, 1'b0, BYTE_NONE));

    run_random(16'hFFFF, 6'd0, 29, 55, 70, 1'b0);
    run_random(16'($urandom_range(50, 1)), 6'($urandom), 55, 29, 70, 1'b0);
    run_random(16'($urandom_range(10, 0)), 6'($urandom), 0, 0, 60, 1'b1);

    settle();
    if (board.pending() != 0) begin
      $error("%0d predicted words never arrived", board.pending());
      board.mismatches += board.pending();
    end
    $display("Checked %0d frames: %0d press, %0d release, %0d long-press and %0d reply words,",
             board.frames_noted, board.press_words, board.release_words,
             board.long_words, board.reply_words);
    $display("across five register settings with idling, back-pressure and a time wrap.");
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
